FILE: rtl/assert_macros.svh
// Assertion macros shared by the culler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the async reset is asserted.
`define VVFC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define VVFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/vvfc_pkg.sv
// Package for the voxel visible-face culler: constants, request codes, face unit command.
package vvfc_pkg;

	localparam int CHUNK_WIDTH_DEF  = 16;
	localparam int CHUNK_HEIGHT_DEF = 256;

	localparam int VERTS_PER_FACE = 4;
	localparam int FIRST_VERTEX_W = 21;
	localparam int FACE_MASK_W    = 6;
	localparam int FACE_COUNT_W   = 3;
	localparam int POS_XY_W       = 4;
	localparam int POS_Z_W        = 8;
	localparam int COL_HEIGHT_W   = 9;
	// Column coordinate with room for a chunk of 64 columns plus one step outside.
	localparam int CRD_W          = 7;

	localparam logic [1:0] REQ_LOAD    = 2'd0;
	localparam logic [1:0] REQ_QUERY   = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	// Side face positions inside the mask.
	localparam logic [1:0] SIDE_FWD   = 2'd0;
	localparam logic [1:0] SIDE_RIGHT = 2'd1;
	localparam logic [1:0] SIDE_BACK  = 2'd2;
	localparam logic [1:0] SIDE_LEFT  = 2'd3;

	typedef struct packed {
		logic       clr;      // start a new voxel
		logic       vld;      // height word present on the memory read port
		logic       own;      // word is the queried column itself
		logic [1:0] side;     // side face that the word decides
		logic       outside;  // neighbor column lies outside the chunk
	} vvfc_fu_cmd_t;

endpackage

FILE: rtl/vvfc_height_mem.sv
// Column height memory: one write port, one registered read port.
module vvfc_height_mem import vvfc_pkg::*; #(
	parameter int DEPTH = CHUNK_WIDTH_DEF * CHUNK_WIDTH_DEF,
	parameter int AW    = $clog2(CHUNK_WIDTH_DEF * CHUNK_WIDTH_DEF),
	parameter int DW    = $clog2(CHUNK_HEIGHT_DEF + 1)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/vvfc_face_unit.sv
// Shared height compare unit that builds the face mask one column word at a time.
module vvfc_face_unit import vvfc_pkg::*; #(
	parameter int HW = $clog2(CHUNK_HEIGHT_DEF + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  vvfc_fu_cmd_t            cmd,
	input  logic [POS_Z_W-1:0]      z,
	input  logic [HW-1:0]           h,
	output logic [FACE_MASK_W-1:0]  mask,
	output logic [FACE_COUNT_W-1:0] count
);

	localparam int CMPW = ((HW > POS_Z_W) ? HW : POS_Z_W) + 1;

	logic            solid_q;
	logic            up_q;
	logic            down_q;
	logic [3:0]      side_q;
	logic [CMPW-1:0] z_ext;
	logic [CMPW-1:0] h_ext;
	logic            z_ge_h;
	logic            z_top;

	assign z_ext  = CMPW'(z);
	assign h_ext  = CMPW'(h);
	// The one compare shared by every step.
	assign z_ge_h = z_ext >= h_ext;
	// Solid voxel with air (or the chunk ceiling) right above it.
	assign z_top  = (z_ext + CMPW'(1)) == h_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			solid_q <= 1'b0;
			up_q    <= 1'b0;
			down_q  <= 1'b0;
			side_q  <= '0;
		end else if (cmd.clr) begin
			solid_q <= 1'b0;
			up_q    <= 1'b0;
			down_q  <= 1'b0;
			side_q  <= '0;
		end else if (cmd.vld) begin
			if (cmd.own) begin
				solid_q <= !z_ge_h;
				up_q    <= z_top;
				down_q  <= (z == '0);
			end else begin
				side_q[cmd.side] <= cmd.outside || z_ge_h;
			end
		end
	end

	always_comb begin
		mask  = solid_q ? {down_q, up_q, side_q} : '0;
		count = '0;
		for (int i = 0; i < FACE_MASK_W; i++) begin
			count = count + FACE_COUNT_W'(mask[i]);
		end
	end

endmodule

FILE: rtl/voxel_visible_face_culler.sv
// Voxel visible-face culler: request decode, read sequencer, vertex counter, result register.
//
// Requests arrive on req_valid/req_ready with fields req_type, pos_x, pos_y,
// pos_z and column_height. A load stores a column height (saturated to the
// chunk height, dropped outside the chunk) and a restart clears the vertex
// counter; both are done on acceptance and return nothing. A query returns one
// transaction on rsp_valid/rsp_ready with face_mask, face_count and
// first_vertex, then advances the vertex counter by four per visible face.
// A query reads its own column and then each in-chunk neighbor from the one
// height memory read port; from acceptance it passes through the read steps,
// a drain step and a step that loads the result register. Queries outside the
// chunk skip the reads and go straight to the drain and result steps.
// req_ready is low while a query is in flight; a finished result waits in the
// output register, and a stalled receiver holds the next query in its final
// cycle until that register frees. Reset clears the sequencer, the counter
// and the result valid; column heights are undefined until loaded.
module voxel_visible_face_culler import vvfc_pkg::*; #(
	parameter int CHUNK_WIDTH  = CHUNK_WIDTH_DEF,
	parameter int CHUNK_HEIGHT = CHUNK_HEIGHT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  logic [1:0]                req_type,
	input  logic [POS_XY_W-1:0]       pos_x,
	input  logic [POS_XY_W-1:0]       pos_y,
	input  logic [POS_Z_W-1:0]        pos_z,
	input  logic [COL_HEIGHT_W-1:0]   column_height,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output logic [FACE_MASK_W-1:0]    face_mask,
	output logic [FACE_COUNT_W-1:0]   face_count,
	output logic [FIRST_VERTEX_W-1:0] first_vertex
);

`include "assert_macros.svh"

	localparam int DEPTH = CHUNK_WIDTH * CHUNK_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int HW    = $clog2(CHUNK_HEIGHT + 1);
	localparam int SW    = (HW > COL_HEIGHT_W) ? HW : COL_HEIGHT_W;

	localparam logic [CRD_W-1:0] CW_C = CRD_W'(CHUNK_WIDTH);
	localparam logic [SW-1:0]    CH_C = SW'(CHUNK_HEIGHT);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_READ  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam logic [2:0] STEP_LAST = 3'd4;

	logic [1:0]                state_q;
	logic [2:0]                step_q;
	logic [CRD_W-1:0]          x_q;
	logic [CRD_W-1:0]          y_q;
	logic [POS_Z_W-1:0]        z_q;
	logic [FIRST_VERTEX_W-1:0] vcnt_q;

	logic                      rsp_valid_q;
	logic [FACE_MASK_W-1:0]    face_mask_q;
	logic [FACE_COUNT_W-1:0]   face_count_q;
	logic [FIRST_VERTEX_W-1:0] first_vertex_q;

	vvfc_fu_cmd_t              cmd_s1;

	logic                      accept;
	logic                      rsp_free;
	logic                      in_chunk_xy;
	logic                      in_chunk_z;
	logic [CRD_W-1:0]          pos_x_ext;
	logic [CRD_W-1:0]          pos_y_ext;
	logic [15:0]               waddr_w;
	logic [SW-1:0]             hin_ext;
	logic [SW-1:0]             hin_sat;
	logic                      mem_we;

	logic [CRD_W-1:0]          nx;
	logic [CRD_W-1:0]          ny;
	logic                      nb_out;
	logic                      nb_own;
	logic [1:0]                nb_side;
	logic [15:0]               raddr_w;
	logic                      mem_re;
	logic [HW-1:0]             mem_rdata;

	logic [FACE_MASK_W-1:0]    fu_mask;
	logic [FACE_COUNT_W-1:0]   fu_count;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_free  = !rsp_valid_q || rsp_ready;

	assign pos_x_ext   = CRD_W'(pos_x);
	assign pos_y_ext   = CRD_W'(pos_y);
	assign in_chunk_xy = (pos_x_ext < CW_C) && (pos_y_ext < CW_C);
	assign in_chunk_z  = SW'(pos_z) < CH_C;

	// Load path: saturate the height and write straight into the memory.
	assign hin_ext = SW'(column_height);
	assign hin_sat = (hin_ext > CH_C) ? CH_C : hin_ext;
	assign waddr_w = 16'(pos_x_ext) + 16'(pos_y_ext) * 16'(CHUNK_WIDTH);
	assign mem_we  = accept && (req_type == REQ_LOAD) && in_chunk_xy;

	// Pick the column for this read step: own column, then the four sides.
	always_comb begin
		nx      = x_q;
		ny      = y_q;
		nb_out  = 1'b0;
		nb_own  = 1'b0;
		nb_side = SIDE_FWD;
		unique case (step_q)
			3'd0: begin
				nb_own = 1'b1;
			end
			3'd1: begin
				nx      = x_q + CRD_W'(1);
				nb_out  = (x_q + CRD_W'(1)) >= CW_C;
				nb_side = SIDE_FWD;
			end
			3'd2: begin
				ny      = y_q + CRD_W'(1);
				nb_out  = (y_q + CRD_W'(1)) >= CW_C;
				nb_side = SIDE_RIGHT;
			end
			3'd3: begin
				nx      = x_q - CRD_W'(1);
				nb_out  = (x_q == '0);
				nb_side = SIDE_BACK;
			end
			3'd4: begin
				ny      = y_q - CRD_W'(1);
				nb_out  = (y_q == '0);
				nb_side = SIDE_LEFT;
			end
			default: begin
				nb_own = 1'b1;
			end
		endcase
	end

	assign raddr_w = 16'(nx) + 16'(ny) * 16'(CHUNK_WIDTH);
	// Skip the read for a neighbor outside the chunk; its face is open anyway.
	assign mem_re  = (state_q == ST_READ) && !nb_out;

	vvfc_height_mem #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (HW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr_w[AW-1:0]),
		.wdata (hin_sat[HW-1:0]),
		.re    (mem_re),
		.raddr (raddr_w[AW-1:0]),
		.rdata (mem_rdata)
	);

	// Command rides alongside the registered read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
		end else begin
			cmd_s1.clr     <= accept && (req_type == REQ_QUERY);
			cmd_s1.vld     <= (state_q == ST_READ);
			cmd_s1.own     <= nb_own;
			cmd_s1.side    <= nb_side;
			cmd_s1.outside <= nb_out;
		end
	end

	vvfc_face_unit #(
		.HW (HW)
	) u_face (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_s1),
		.z      (z_q),
		.h      (mem_rdata),
		.mask   (fu_mask),
		.count  (fu_count)
	);

	// Sequencer and vertex counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			vcnt_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (accept) begin
						unique case (req_type)
							REQ_QUERY: begin
								// Out-of-chunk voxel counts as air: skip the reads.
								state_q <= (in_chunk_xy && in_chunk_z) ? ST_READ : ST_DRAIN;
							end
							REQ_RESTART: begin
								vcnt_q <= '0;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_READ: begin
					if (step_q == STEP_LAST) begin
						state_q <= ST_DRAIN;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// Hold until the result register frees, then advance the counter.
					if (rsp_free) begin
						vcnt_q  <= vcnt_q
							+ FIRST_VERTEX_W'(fu_count) * FIRST_VERTEX_W'(VERTS_PER_FACE);
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Latch the query coordinates.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= pos_x_ext;
			y_q <= pos_y_ext;
			z_q <= pos_z;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && rsp_free) begin
			face_mask_q    <= fu_mask;
			face_count_q   <= fu_count;
			first_vertex_q <= vcnt_q;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign face_mask    = face_mask_q;
	assign face_count   = face_count_q;
	assign first_vertex = first_vertex_q;

	`VVFC_ASSERT(a_count_matches_mask, clk, arst_n, rsp_valid |-> face_count == FACE_COUNT_W'($countones(face_mask)), "face_count disagrees with face_mask")
	`VVFC_ASSERT(a_first_vertex_pre, clk, arst_n, (state_q == ST_DONE && rsp_free) |=> first_vertex == $past(vcnt_q), "first_vertex is not the counter before the query")
	`VVFC_ASSERT(a_step_bound, clk, arst_n, (state_q == ST_READ) |-> step_q <= STEP_LAST, "read step past the last neighbor")
	`VVFC_ASSERT(a_read_cmd_origin, clk, arst_n, cmd_s1.vld |-> $past(state_q) == ST_READ, "height word tagged valid outside the read phase")

endmodule

FILE: bench/tb_voxel_visible_face_culler.sv
// Self-checking testbench for the voxel visible-face culler with a behavioral face predictor.
`timescale 1ns / 1ps

module tb_voxel_visible_face_culler;
	import vvfc_pkg::*;

	// Chunk geometry as built by the instance below (package defaults).
	localparam int CHUNK_W = CHUNK_WIDTH_DEF;
	localparam int CHUNK_H = CHUNK_HEIGHT_DEF;
	localparam int COLUMNS = CHUNK_W * CHUNK_W;

	// Request code the block must ignore.
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// Face bits inside the mask.
	localparam int FACE_FWD   = 0;
	localparam int FACE_RIGHT = 1;
	localparam int FACE_BACK  = 2;
	localparam int FACE_LEFT  = 3;
	localparam int FACE_UP    = 4;
	localparam int FACE_DOWN  = 5;

	// Isolated one-voxel column shows all six faces: 24 vertices per query.
	// Short back-to-back burst of such queries with no idle on either side.
	localparam int FLOOD_QUERIES = 24;
	localparam int RANDOM_ITEMS = 650;

	typedef struct packed {
		logic [1:0]              kind;
		logic [POS_XY_W-1:0]     x;
		logic [POS_XY_W-1:0]     y;
		logic [POS_Z_W-1:0]      z;
		logic [COL_HEIGHT_W-1:0] height;
	} culler_req_t;

	typedef struct packed {
		logic [FACE_MASK_W-1:0]    mask;
		logic [FACE_COUNT_W-1:0]   count;
		logic [FIRST_VERTEX_W-1:0] first;
	} face_result_t;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      req_valid = 1'b0;
	logic                      req_ready;
	logic [1:0]                req_type = REQ_LOAD;
	logic [POS_XY_W-1:0]       pos_x = '0;
	logic [POS_XY_W-1:0]       pos_y = '0;
	logic [POS_Z_W-1:0]        pos_z = '0;
	logic [COL_HEIGHT_W-1:0]   column_height = '0;
	logic                      rsp_valid;
	logic                      rsp_ready = 1'b0;
	logic [FACE_MASK_W-1:0]    face_mask;
	logic [FACE_COUNT_W-1:0]   face_count;
	logic [FIRST_VERTEX_W-1:0] first_vertex;

	voxel_visible_face_culler i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req_type     (req_type),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.column_height(column_height),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.face_mask    (face_mask),
		.face_count   (face_count),
		.first_vertex (first_vertex)
	);

	// Transactions waiting to be driven, and face results still owed by the block.
	culler_req_t  pending_reqs[$];
	face_result_t expected_faces[$];
	int unsigned  error_count = 0;

	// Predictor state: stored column heights and the running vertex index.
	logic [COL_HEIGHT_W-1:0]   height_mirror [COLUMNS];
	logic [FIRST_VERTEX_W-1:0] vertex_total = '0;

	// Heights as the stimulus generator last loaded them, used to aim queries at solid voxels.
	int stim_heights [COLUMNS];

	// Idle shaping: quiet stretches come and go on their own, flood_mode pins them on.
	bit steady_stretch = 1'b0;
	bit flood_mode = 1'b0;
	int unsigned steady_left = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Gap length: mostly none or short, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// A face is open when the neighbor is out of the chunk or is air.
	function automatic bit face_open(int x, int y, int z);
		if (z < 0 || z >= CHUNK_H)
			return 1'b1;
		if (x < 0 || y < 0 || x >= CHUNK_W || y >= CHUNK_W)
			return 1'b1;
		return z >= int'(height_mirror[x + y * CHUNK_W]);
	endfunction

	// Advance the predictor by one accepted transaction; a query queues its face result.
	task automatic apply_request(input culler_req_t r);
		face_result_t res;
		int x;
		int y;
		int z;
		x = r.x;
		y = r.y;
		z = r.z;
		case (r.kind)
			REQ_LOAD: begin
				// Drop loads outside the chunk, saturate tall columns to the chunk height.
				if (x < CHUNK_W && y < CHUNK_W)
					height_mirror[x + y * CHUNK_W] = (r.height > CHUNK_H) ?
						COL_HEIGHT_W'(CHUNK_H) : r.height;
			end
			REQ_RESTART: begin
				vertex_total = '0;
			end
			REQ_QUERY: begin
				res = '0;
				res.first = vertex_total;
				// Air or out-of-chunk voxels report no faces and hold the counter.
				if (x < CHUNK_W && y < CHUNK_W && z < CHUNK_H &&
						z < int'(height_mirror[x + y * CHUNK_W])) begin
					res.mask[FACE_FWD]   = face_open(x + 1, y, z);
					res.mask[FACE_RIGHT] = face_open(x, y + 1, z);
					res.mask[FACE_BACK]  = face_open(x - 1, y, z);
					res.mask[FACE_LEFT]  = face_open(x, y - 1, z);
					res.mask[FACE_UP]    = face_open(x, y, z + 1);
					res.mask[FACE_DOWN]  = face_open(x, y, z - 1);
					for (int i = 0; i < FACE_MASK_W; i++)
						res.count = res.count + FACE_COUNT_W'(res.mask[i]);
					// Wraps modulo 2^21 through the vector width.
					vertex_total = vertex_total + FIRST_VERTEX_W'(VERTS_PER_FACE * res.count);
				end
				expected_faces.push_back(res);
			end
			default: begin
				// Unused code: no state change, no result.
			end
		endcase
	endtask

	task automatic report_mismatch(input string what, input face_result_t want,
			input face_result_t got);
		error_count++;
		if (error_count <= 10)
			$display("[%0t] %s: expected mask %b count %0d first %0d, got mask %b count %0d first %0d",
				$time, what, want.mask, want.count, want.first, got.mask, got.count, got.first);
	endtask

	// Queue one transaction and keep the generator's view of the heights in step.
	task automatic push_req(input logic [1:0] kind, input int x, input int y, input int z,
			input int h);
		culler_req_t r;
		r.kind   = kind;
		r.x      = POS_XY_W'(x);
		r.y      = POS_XY_W'(y);
		r.z      = POS_Z_W'(z);
		r.height = COL_HEIGHT_W'(h);
		if (kind == REQ_LOAD && x < CHUNK_W && y < CHUNK_W)
			stim_heights[x + y * CHUNK_W] = (h > CHUNK_H) ? CHUNK_H : h;
		pending_reqs.push_back(r);
	endtask

	// Height for a random load: mostly low so neighbors differ at the same z.
	function automatic int pick_height();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return $urandom_range(0, 12);
		if (r < 65)
			return 0;
		if (r < 75)
			return CHUNK_H;
		if (r < 85)
			return $urandom_range(CHUNK_H + 1, (1 << COL_HEIGHT_W) - 1);
		return $urandom_range(0, CHUNK_H);
	endfunction

	// Toggle quiet stretches at the falling edge, away from the sampling edge.
	always @(negedge clk) begin
		if (steady_left > 0) begin
			steady_left--;
		end else begin
			steady_stretch = ($urandom_range(0, 3) == 0);
			steady_left = $urandom_range(100, 1500);
		end
	end

	// Driver: hold the transaction until accepted, then advance the predictor and
	// launch the next one, possibly after a gap.
	always @(posedge clk or negedge arst_n) begin : req_driver
		static culler_req_t active_req;
		static int unsigned idle_left = 0;
		bit launch;
		if (!arst_n) begin
			req_valid <= 1'b0;
			idle_left = 0;
		end else begin
			if (req_valid && req_ready)
				apply_request(active_req);
			launch = req_valid && !req_ready;
			if (!launch) begin
				if (idle_left > 0) begin
					idle_left--;
				end else if (pending_reqs.size() > 0) begin
					active_req = pending_reqs.pop_front();
					req_type      <= active_req.kind;
					pos_x         <= active_req.x;
					pos_y         <= active_req.y;
					pos_z         <= active_req.z;
					column_height <= active_req.height;
					launch = 1'b1;
					idle_left = (steady_stretch || flood_mode) ? 0 : pick_gap();
				end
			end
			req_valid <= launch;
		end
	end

	// Monitor: check each accepted result against the oldest prediction and stall at random.
	always @(posedge clk or negedge arst_n) begin : rsp_monitor
		static int unsigned stall_left = 0;
		face_result_t got;
		face_result_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				got.mask  = face_mask;
				got.count = face_count;
				got.first = first_vertex;
				if (expected_faces.size() == 0) begin
					report_mismatch("unexpected face result", '0, got);
				end else begin
					want = expected_faces.pop_front();
					if (got !== want)
						report_mismatch("face result mismatch", want, got);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
				if (!steady_stretch && !flood_mode && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// Wait at the falling edge until every queued transaction is in and every result is out.
	task automatic drain();
		while (pending_reqs.size() > 0 || req_valid || expected_faces.size() > 0)
			@(negedge clk);
	endtask

	initial begin : stimulus
		int unsigned r;
		int x;
		int y;
		int z;
		int h;
		face_result_t leftover;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: corner columns, height extremes and saturation, every request code.
		push_req(REQ_LOAD, 0, 0, 0, (1 << COL_HEIGHT_W) - 1);  // saturates to full height
		push_req(REQ_LOAD, 1, 0, 255, 0);
		push_req(REQ_LOAD, 0, 1, 0, CHUNK_H + 1);
		push_req(REQ_QUERY, 0, 0, CHUNK_H - 1, 0);            // top voxel: up face at the ceiling
		push_req(REQ_QUERY, 0, 0, 0, (1 << COL_HEIGHT_W) - 1); // bottom voxel: down face at floor
		push_req(REQ_QUERY, 0, 0, 128, 0);
		push_req(REQ_UNUSED, 15, 15, 255, (1 << COL_HEIGHT_W) - 1);
		push_req(REQ_LOAD, 15, 15, 0, 1);
		push_req(REQ_LOAD, 14, 15, 0, CHUNK_H);
		push_req(REQ_LOAD, 15, 14, 0, 0);
		push_req(REQ_QUERY, 15, 15, 0, 0);
		push_req(REQ_QUERY, 15, 15, 1, 0);                    // air just above the column
		push_req(REQ_QUERY, 15, 15, 255, 0);
		push_req(REQ_RESTART, 7, 9, 200, 300);
		push_req(REQ_QUERY, 0, 0, CHUNK_H - 1, 0);
		push_req(REQ_LOAD, 0, 0, 0, 0);
		push_req(REQ_QUERY, 0, 0, 0, 0);                      // empty column
		drain();

		// Load every column so any query reads only written heights.
		for (y = 0; y < CHUNK_W; y++)
			for (x = 0; x < CHUNK_W; x++)
				push_req(REQ_LOAD, x, y, $urandom_range(0, 255), pick_height());

		// Random mix, weighted toward queries of solid voxels near column tops.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			r = $urandom_range(0, 99);
			x = $urandom_range(0, CHUNK_W - 1);
			y = $urandom_range(0, CHUNK_W - 1);
			if (r < 30) begin
				push_req(REQ_LOAD, x, y, $urandom_range(0, 255), pick_height());
			end else if (r < 88) begin
				h = stim_heights[x + y * CHUNK_W];
				r = $urandom_range(0, 99);
				if (h > 0 && r < 70)
					z = $urandom_range(0, h - 1);
				else if (h > 0 && r < 80)
					z = h - 1;
				else if (h < CHUNK_H && r < 88)
					z = h;
				else
					z = $urandom_range(0, 255);
				push_req(REQ_QUERY, x, y, z, $urandom_range(0, (1 << COL_HEIGHT_W) - 1));
			end else if (r < 94) begin
				push_req(REQ_RESTART, x, y, $urandom_range(0, 255),
					$urandom_range(0, (1 << COL_HEIGHT_W) - 1));
			end else begin
				push_req(REQ_UNUSED, x, y, $urandom_range(0, 255),
					$urandom_range(0, (1 << COL_HEIGHT_W) - 1));
			end
		end
		drain();

		// Back-to-back queries of an isolated one-voxel column.
		flood_mode = 1'b1;
		push_req(REQ_LOAD, 5, 5, 0, 1);
		push_req(REQ_LOAD, 4, 5, 0, 0);
		push_req(REQ_LOAD, 6, 5, 0, 0);
		push_req(REQ_LOAD, 5, 4, 0, 0);
		push_req(REQ_LOAD, 5, 6, 0, 0);
		push_req(REQ_RESTART, 0, 0, 0, 0);
		for (int n = 0; n < FLOOD_QUERIES; n++)
			push_req(REQ_QUERY, 5, 5, 0, $urandom_range(0, (1 << COL_HEIGHT_W) - 1));
		drain();

		// Let any stray result surface before the verdict.
		repeat (20) @(posedge clk);
		@(negedge clk);
		while (expected_faces.size() > 0) begin
			leftover = expected_faces.pop_front();
			report_mismatch("face result never arrived", leftover, '0);
		end
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#(64'd20_000_000);
		$display("FAIL");
		$finish;
	end

endmodule
